[design/spfe_pkg.sv]
package spfe_pkg;

   // colour and table geometry
   localparam int COLOR_W      = 6;
   localparam int COLOR_COUNT  = 64;
   localparam int STRIP_PIXELS = 8;
   localparam int TABLE_SIZE   = COLOR_COUNT * COLOR_COUNT;
   localparam int ADDR_W       = $clog2(TABLE_SIZE);
   localparam int CC_LOG       = $clog2(COLOR_COUNT);
   localparam int STRIP_W      = COLOR_W * STRIP_PIXELS;
   localparam int PIX_W        = $clog2(STRIP_PIXELS);
   localparam int PAL_COUNT    = 4;
   localparam int PAL_W        = 2;
   localparam int ENTRY_W      = 2;
   localparam int ERR_W        = 8;
   localparam int TOT_W        = $clog2(STRIP_PIXELS * 255 + 1);
   localparam int PLANE_W      = 8;
   localparam int PAL_DATA_W   = 3 * COLOR_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_BG   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL3 = 3'd4;

   // request kinds
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_ENCODE = 1'b1;

   // candidate entries of a sub-palette
   localparam logic [ENTRY_W-1:0] ENTRY_1 = 2'd1;
   localparam logic [ENTRY_W-1:0] ENTRY_2 = 2'd2;
   localparam logic [ENTRY_W-1:0] ENTRY_3 = 2'd3;

   // program steps
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] ST_IDLE       = 5'd0;
   localparam logic [STEP_W-1:0] ST_BG         = 5'd1;
   localparam logic [STEP_W-1:0] ST_CAND_FIRST = 5'd2;
   localparam logic [STEP_W-1:0] ST_CAND_LAST  = 5'd13;
   localparam logic [STEP_W-1:0] ST_DRAIN      = 5'd14;
   localparam logic [STEP_W-1:0] ST_CMP_FIRST  = 5'd15;
   localparam logic [STEP_W-1:0] ST_CMP_LAST   = 5'd18;
   localparam logic [STEP_W-1:0] ST_OUT        = 5'd19;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_BG,
      RD_CAND
   } rd_sel_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_IDLE,
      JMP_PIXEL,
      JMP_OUT
   } jump_type;

   typedef struct packed {
      rd_sel_type           rd_sel;
      logic [PAL_W-1:0]     pal;
      logic [ENTRY_W-1:0]   entry;
      jump_type             jump;
      logic                 cmp_en;
      logic                 cmp_first;
      logic                 out_load;
      logic                 clr;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      rd_sel: RD_NONE, pal: '0, entry: '0, jump: JMP_NEXT,
      cmp_en: 1'b0, cmp_first: 1'b0, out_load: 1'b0, clr: 1'b0
   };

   function automatic ucode_type cand_word(input logic [PAL_W-1:0] pal,
                                           input logic [ENTRY_W-1:0] entry,
                                           input logic last);
      ucode_type w;
      w        = UC_NOP;
      w.rd_sel = RD_CAND;
      w.pal    = pal;
      w.entry  = entry;
      w.jump   = last ? JMP_PIXEL : JMP_NEXT;
      return w;
   endfunction

   function automatic ucode_type cmp_word(input logic [PAL_W-1:0] pal, input logic first);
      ucode_type w;
      w           = UC_NOP;
      w.pal       = pal;
      w.cmp_en    = 1'b1;
      w.cmp_first = first;
      return w;
   endfunction

   // control store
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = UC_NOP;
      unique case (step)
         ST_IDLE: begin
            w.jump = JMP_IDLE;
            w.clr  = 1'b1;
         end
         ST_BG:                 w.rd_sel = RD_BG;
         ST_CAND_FIRST + 5'd0:  w = cand_word(2'd0, ENTRY_1, 1'b0);
         ST_CAND_FIRST + 5'd1:  w = cand_word(2'd0, ENTRY_2, 1'b0);
         ST_CAND_FIRST + 5'd2:  w = cand_word(2'd0, ENTRY_3, 1'b0);
         ST_CAND_FIRST + 5'd3:  w = cand_word(2'd1, ENTRY_1, 1'b0);
         ST_CAND_FIRST + 5'd4:  w = cand_word(2'd1, ENTRY_2, 1'b0);
         ST_CAND_FIRST + 5'd5:  w = cand_word(2'd1, ENTRY_3, 1'b0);
         ST_CAND_FIRST + 5'd6:  w = cand_word(2'd2, ENTRY_1, 1'b0);
         ST_CAND_FIRST + 5'd7:  w = cand_word(2'd2, ENTRY_2, 1'b0);
         ST_CAND_FIRST + 5'd8:  w = cand_word(2'd2, ENTRY_3, 1'b0);
         ST_CAND_FIRST + 5'd9:  w = cand_word(2'd3, ENTRY_1, 1'b0);
         ST_CAND_FIRST + 5'd10: w = cand_word(2'd3, ENTRY_2, 1'b0);
         ST_CAND_LAST:          w = cand_word(2'd3, ENTRY_3, 1'b1);
         ST_DRAIN:              w = UC_NOP;
         ST_CMP_FIRST:          w = cmp_word(2'd0, 1'b1);
         ST_CMP_FIRST + 5'd1:   w = cmp_word(2'd1, 1'b0);
         ST_CMP_FIRST + 5'd2:   w = cmp_word(2'd2, 1'b0);
         ST_CMP_LAST:           w = cmp_word(2'd3, 1'b0);
         ST_OUT: begin
            w.jump     = JMP_OUT;
            w.out_load = 1'b1;
         end
         default: begin
            w.jump = JMP_OUT;
         end
      endcase
      return w;
   endfunction

endpackage

[design/strip_palette_fit_encoder.sv]
// Strip palette fit encoder.
// Request channel (req_*): req_type low writes one byte of the colour error
// table at req_table_index; req_type high encodes the eight pixels in
// req_pixel_strip. A table write completes in the transfer cycle and gives no
// response; req_ready stays high, so writes can follow back to back.
// An encode reads the table 13 times per pixel (background plus twelve
// sub-palette candidates) through its single port, 104 reads in all, then
// compares the four summed errors. rsp_valid rises when the output step
// loads the response, and the next request is taken only once the sequencer
// is back in idle: one encode at a time, bounded by the table read port.
// Response channel (rsp_*): palette index, two bitplanes with pixel 0 in
// bit 7 and the attribute byte. The response sits in an output register, so
// a stalled receiver does not hold off table writes; a second encode waits in
// its last step until the previous response has been taken.
// Configuration (csr_*): always ready; index 0 is the background colour,
// 1 to 4 the sub-palettes. Write only while no encode is in flight.
// Reset clears the configuration and the sequencer; table contents are
// undefined until written.
module strip_palette_fit_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [11:0]                      req_table_index,
   input  logic [7:0]                       req_table_value,
   input  logic [47:0]                      req_pixel_strip,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_palette_index,
   output logic [7:0]                       rsp_low_plane,
   output logic [7:0]                       rsp_high_plane,
   output logic [7:0]                       rsp_attribute_byte,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [spfe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spfe_pkg::CSR_DATA_W-1:0]  csr_data
);
   import spfe_pkg::*;

   // configuration
   logic [COLOR_W-1:0]    bg_ff, bg_in;
   logic [PAL_DATA_W-1:0] pal_ff [PAL_COUNT];
   logic [PAL_DATA_W-1:0] pal_in [PAL_COUNT];

   // sequencer
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [PIX_W-1:0]      pix_cnt_ff, pix_cnt_in;
   logic [STRIP_W-1:0]    strip_ff, strip_in;
   ucode_type             uc;

   // table
   logic [ERR_W-1:0]      delta_mem [TABLE_SIZE];
   logic [ERR_W-1:0]      rd_data_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic [COLOR_W-1:0]    src_color;
   logic [COLOR_W-1:0]    cand_color;
   logic                  tbl_wr;

   // read tag, delayed to line up with rd_data_ff
   rd_sel_type            dly_sel_ff, dly_sel_in;
   logic [PAL_W-1:0]      dly_pal_ff, dly_pal_in;
   logic [ENTRY_W-1:0]    dly_entry_ff, dly_entry_in;

   // datapath
   logic [ERR_W-1:0]      bg_err_ff, bg_err_in;
   logic [ERR_W-1:0]      cur_err_ff, cur_err_in;
   logic [ENTRY_W-1:0]    cur_e_ff, cur_e_in;
   logic [TOT_W-1:0]      total_ff [PAL_COUNT];
   logic [TOT_W-1:0]      total_in [PAL_COUNT];
   logic [PLANE_W-1:0]    lo_ff [PAL_COUNT];
   logic [PLANE_W-1:0]    lo_in [PAL_COUNT];
   logic [PLANE_W-1:0]    hi_ff [PAL_COUNT];
   logic [PLANE_W-1:0]    hi_in [PAL_COUNT];
   logic [TOT_W-1:0]      best_tot_ff, best_tot_in;
   logic [PAL_W-1:0]      best_pal_ff, best_pal_in;
   logic [ERR_W-1:0]      base_err, new_err;
   logic [ENTRY_W-1:0]    base_e, new_e;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PAL_W-1:0]      rsp_pal_ff, rsp_pal_in;
   logic [PLANE_W-1:0]    rsp_lo_ff, rsp_lo_in;
   logic [PLANE_W-1:0]    rsp_hi_ff, rsp_hi_in;

   logic                  req_xfer;
   logic                  rsp_free;
   logic                  pix_last;

   assign uc        = ucode_rom(step_ff);
   assign req_ready = (step_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign pix_last  = (pix_cnt_ff == PIX_W'(STRIP_PIXELS - 1));
   assign tbl_wr    = req_xfer && (req_type == REQ_WRITE) &&
                      ({1'b0, req_table_index} < 13'(TABLE_SIZE));

   // configuration writes
   always_comb begin
      bg_in = bg_ff;
      for (int p = 0; p < PAL_COUNT; p++) begin
         pal_in[p] = pal_ff[p];
      end
      if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_BG: bg_in = csr_data[COLOR_W-1:0];
            [CSR_PAL0:CSR_PAL3]:
               pal_in[PAL_W'(csr_index - CSR_PAL0)] = csr_data[PAL_DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // step counter and jumps
   always_comb begin
      step_in    = step_ff;
      pix_cnt_in = pix_cnt_ff;
      strip_in   = strip_ff;
      unique case (uc.jump)
         JMP_NEXT: step_in = step_ff + 5'd1;
         JMP_IDLE: begin
            pix_cnt_in = '0;
            if (req_xfer && (req_type == REQ_ENCODE)) begin
               step_in  = ST_BG;
               strip_in = req_pixel_strip[STRIP_W-1:0];
            end
         end
         JMP_PIXEL: begin
            step_in    = pix_last ? ST_DRAIN : ST_BG;
            pix_cnt_in = pix_cnt_ff + 1'b1;
            strip_in   = strip_ff << COLOR_W;
         end
         JMP_OUT: begin
            if (rsp_free) begin
               step_in = ST_IDLE;
            end
         end
         default: step_in = ST_IDLE;
      endcase
   end

   // table address for this step
   always_comb begin
      src_color = strip_ff[STRIP_W-1 -: COLOR_W];
      case (uc.entry)
         ENTRY_1: cand_color = pal_ff[uc.pal][COLOR_W-1:0];
         ENTRY_2: cand_color = pal_ff[uc.pal][2*COLOR_W-1:COLOR_W];
         ENTRY_3: cand_color = pal_ff[uc.pal][3*COLOR_W-1:2*COLOR_W];
         default: cand_color = bg_ff;
      endcase
      if (uc.rd_sel == RD_BG) begin
         cand_color = bg_ff;
      end
      rd_addr = ADDR_W'((ADDR_W + COLOR_W)'(src_color) << CC_LOG) + ADDR_W'(cand_color);
   end

   // error compare and accumulation on returned reads
   always_comb begin
      dly_sel_in   = uc.rd_sel;
      dly_pal_in   = uc.pal;
      dly_entry_in = uc.entry;
      bg_err_in    = bg_err_ff;
      cur_err_in   = cur_err_ff;
      cur_e_in     = cur_e_ff;
      best_tot_in  = best_tot_ff;
      best_pal_in  = best_pal_ff;
      for (int p = 0; p < PAL_COUNT; p++) begin
         total_in[p] = uc.clr ? '0 : total_ff[p];
         lo_in[p]    = lo_ff[p];
         hi_in[p]    = hi_ff[p];
      end

      // ties keep the lower entry, so only a strictly smaller error wins
      base_err = (dly_entry_ff == ENTRY_1) ? bg_err_ff : cur_err_ff;
      base_e   = (dly_entry_ff == ENTRY_1) ? '0 : cur_e_ff;
      if (rd_data_ff < base_err) begin
         new_err = rd_data_ff;
         new_e   = dly_entry_ff;
      end else begin
         new_err = base_err;
         new_e   = base_e;
      end

      case (dly_sel_ff)
         RD_BG: bg_err_in = rd_data_ff;
         RD_CAND: begin
            if (dly_entry_ff == ENTRY_3) begin
               total_in[dly_pal_ff] = total_ff[dly_pal_ff] + TOT_W'(new_err);
               lo_in[dly_pal_ff]    = {lo_ff[dly_pal_ff][PLANE_W-2:0], new_e[0]};
               hi_in[dly_pal_ff]    = {hi_ff[dly_pal_ff][PLANE_W-2:0], new_e[1]};
            end else begin
               cur_err_in = new_err;
               cur_e_in   = new_e;
            end
         end
         default: ;
      endcase

      if (uc.cmp_en) begin
         if (uc.cmp_first || (total_ff[uc.pal] < best_tot_ff)) begin
            best_tot_in = total_ff[uc.pal];
            best_pal_in = uc.pal;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pal_in   = rsp_pal_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      if (uc.out_load && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_pal_in   = best_pal_ff;
         rsp_lo_in    = lo_ff[best_pal_ff];
         rsp_hi_in    = hi_ff[best_pal_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff        <= '0;
         step_ff      <= ST_IDLE;
         dly_sel_ff   <= RD_NONE;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < PAL_COUNT; p++) begin
            pal_ff[p] <= '0;
         end
      end else begin
         bg_ff        <= bg_in;
         step_ff      <= step_in;
         dly_sel_ff   <= dly_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int p = 0; p < PAL_COUNT; p++) begin
            pal_ff[p] <= pal_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_cnt_ff   <= pix_cnt_in;
      strip_ff     <= strip_in;
      dly_pal_ff   <= dly_pal_in;
      dly_entry_ff <= dly_entry_in;
      bg_err_ff    <= bg_err_in;
      cur_err_ff   <= cur_err_in;
      cur_e_ff     <= cur_e_in;
      best_tot_ff  <= best_tot_in;
      best_pal_ff  <= best_pal_in;
      rsp_pal_ff   <= rsp_pal_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_hi_ff    <= rsp_hi_in;
      for (int p = 0; p < PAL_COUNT; p++) begin
         total_ff[p] <= total_in[p];
         lo_ff[p]    <= lo_in[p];
         hi_ff[p]    <= hi_in[p];
      end
   end

   // error table
   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         delta_mem[req_table_index[ADDR_W-1:0]] <= req_table_value;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.rd_sel != RD_NONE) begin
         rd_data_ff <= delta_mem[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_palette_index  = rsp_pal_ff;
   assign rsp_low_plane      = 8'(rsp_lo_ff);
   assign rsp_high_plane     = 8'(rsp_hi_ff);
   assign rsp_attribute_byte = {4{rsp_pal_ff}};

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ST_OUT)
      else $error("sequencer step out of program");

   a_encode_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_ENCODE) |=> step_ff == ST_BG)
      else $error("encode transfer did not start the program");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == ST_OUT))
      else $error("response raised outside the output step");

   a_cand_entry: assert property (@(posedge clock) disable iff (reset)
      dly_sel_ff == RD_CAND |-> dly_entry_ff != '0)
      else $error("candidate read tagged with the background entry");

endmodule
